// ===== hdl/pfa_pkg.sv =====
// Package for the page frame allocator: command codes, state type, control structs.
// No dependencies.
package pfa_pkg;

    localparam int FRAME_COUNT = 32768;

    localparam logic [2:0] KIND_ALLOC    = 3'd0;
    localparam logic [2:0] KIND_FREE     = 3'd1;
    localparam logic [2:0] KIND_RALLOC   = 3'd2;
    localparam logic [2:0] KIND_RFREE    = 3'd3;
    localparam logic [2:0] KIND_INIT     = 3'd4;

    localparam logic [1:0] CFG_USABLE    = 2'd0;
    localparam logic [1:0] CFG_RES_LOW   = 2'd1;
    localparam logic [1:0] CFG_RES_HIGH  = 2'd2;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_FILL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_RD,
        S_FREE_RD,
        S_FREE_WR,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        POOL_GEN,
        POOL_RES
    } t_pool;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the input item
        logic clr_start;    // begin the map clearing sweep
        logic clr_step;     // write one byte of the sweep
        logic clr_zero;     // sweep writes zero everywhere (after reset)
        logic scan_start;   // load the scan pointer for the selected pool
        logic scan_rd;      // issue a bitmap read at the scan pointer
        logic scan_chk;     // evaluate the registered byte
        t_pool pool;
        logic fill_mode;    // scan result goes onto the stack
        logic pop_rd;       // read stack top
        logic pop_done;     // result from popped entry
        logic push;         // push captured frame
        logic bit_rd;       // read byte of captured frame
        logic bit_clr;      // clear the captured frame's bit
        logic init_ptrs;    // reset scan pointers and stack at initialize
        logic fail;         // report no free frame
        logic zero_res;     // report frame 0, status 0
        logic out_load;     // move result into the output register
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic frame_ok;
        logic stack_empty;
        logic stack_full;
        logic clr_done;
        logic scan_hit;
        logic scan_last;    // the byte just checked was the last one of the sweep
        logic pool_empty;
    } t_stat;

endpackage

// ===== hdl/pfa_datapath.sv =====
// Datapath of the page frame allocator: bitmap memory, free stack, scan pointers.
// Depends on pfa_pkg.
module pfa_datapath import pfa_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic [2:0]  i_kind,
    input  logic [14:0] i_frame,
    input  logic [15:0] i_usable,
    input  logic [15:0] i_res_low,
    input  logic [15:0] i_res_high,
    output logic [14:0] o_frame_out,
    output logic        o_status
);
    localparam int MAP_BYTES = (FRAME_COUNT + 7) / 8;
    localparam int BW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int BWX = BW + 1;               // can hold MAP_BYTES
    localparam int FW  = BW + 3;
    localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TW  = $clog2(STACK_DEPTH + 1);
    localparam int LW  = 21;                   // frame limits up to 2^15

    logic [7:0]  mem_map [MAP_BYTES];
    logic [14:0] mem_stk [STACK_DEPTH];

    logic [2:0]     r_kind;
    logic [14:0]    r_frame;
    logic [BWX-1:0] r_gen_ptr, r_res_ptr;
    logic [TW-1:0]  r_top;
    logic [BWX-1:0] r_cur, r_start, r_end, r_first;
    logic           r_wrapped;
    logic [7:0]     r_rdata;
    logic [14:0]    r_sdata;
    logic [14:0]    r_res;
    logic           r_stat;
    logic [14:0]    r_out_frame;
    logic           r_out_stat;
    logic [BWX-1:0] r_clr;

    // bounds
    logic [LW-1:0]  lim;
    logic [BWX-1:0] gen_start, gen_end, res_start, res_end, low_b;
    logic [BWX-1:0] p_start, p_end, p_ptr, p_first;

    function automatic logic [BWX-1:0] byte_of(input logic [15:0] f);
        logic [BWX-1:0] b;
        if (LW'(f[15:3]) >= LW'(MAP_BYTES)) b = BWX'(MAP_BYTES);
        else b = BWX'(f[15:3]);
        return b;
    endfunction

    always_comb begin
        lim = ({5'd0, i_usable} < LW'(FRAME_COUNT)) ? LW'(i_usable) : LW'(FRAME_COUNT);
        gen_start = byte_of(i_res_high);
        gen_end   = BWX'((lim + LW'(7)) >> 3);
        res_start = byte_of(i_res_low);
        res_end   = byte_of(i_res_high);
        low_b     = res_start;
        p_start   = (i_ctrl.pool == POOL_RES) ? res_start : gen_start;
        p_end     = (i_ctrl.pool == POOL_RES) ? res_end : gen_end;
        p_ptr     = (i_ctrl.pool == POOL_RES) ? r_res_ptr : r_gen_ptr;
        p_first   = (p_ptr < p_start || p_ptr >= p_end) ? p_start : p_ptr;
    end

    // free bits of the registered byte
    logic [LW-1:0] base, diff;
    logic [7:0]    fmask;
    logic [2:0]    fbit;
    logic          hit;
    always_comb begin
        base  = LW'(r_cur) << 3;
        diff  = lim - base;
        fmask = ~r_rdata;
        if (base >= lim) fmask = 8'd0;
        else if (diff < LW'(8)) fmask = fmask & ((8'd1 << diff[2:0]) - 8'd1);
        hit  = |fmask;
        fbit = 3'd0;
        for (int k = 7; k >= 0; k--) if (fmask[k]) fbit = 3'(k);
    end

    logic [BWX-1:0] nxt;
    logic           nxt_wrap, last;
    always_comb begin
        nxt = r_cur + BWX'(1);
        nxt_wrap = r_wrapped;
        if (!r_wrapped && nxt >= r_end) begin
            nxt = r_start;
            nxt_wrap = 1'b1;
        end
        last = (nxt_wrap && nxt >= r_first) || (r_wrapped && nxt >= r_first);
    end

    logic [FW-1:0] fidx;
    assign fidx = FW'(r_frame);

    // bitmap port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_step)
            mem_map[r_clr[BW-1:0]] <= (r_clr < low_b && !i_ctrl.clr_zero) ? 8'hff : 8'h00;
        else if (i_ctrl.scan_chk && hit)
            mem_map[r_cur[BW-1:0]] <= r_rdata | (8'd1 << fbit);
        else if (i_ctrl.bit_clr)
            mem_map[fidx[FW-1:3]] <= r_rdata & ~(8'd1 << fidx[2:0]);
        if (i_ctrl.scan_rd) r_rdata <= mem_map[r_cur[BW-1:0]];
        else if (i_ctrl.bit_rd) r_rdata <= mem_map[fidx[FW-1:3]];
    end

    logic [TW-1:0] top_m1;
    assign top_m1 = r_top - TW'(1);

    // stack port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push)
            mem_stk[top_m1[SW-1:0]] <= r_frame;
        else if (i_ctrl.scan_chk && hit && i_ctrl.fill_mode)
            mem_stk[top_m1[SW-1:0]] <= 15'(LW'(r_cur) * LW'(8) + LW'(fbit));
        if (i_ctrl.pop_rd) r_sdata <= mem_stk[r_top[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_ptr  <= '0;
            r_res_ptr  <= '0;
            r_top      <= TW'(STACK_DEPTH);
            r_out_stat <= 1'b0;
            r_clr      <= '0;
        end else begin
            if (i_ctrl.init_ptrs) begin
                r_gen_ptr <= gen_start;
                r_res_ptr <= low_b;
                r_top     <= TW'(STACK_DEPTH);
            end
            if (i_ctrl.scan_chk && hit) begin
                if (i_ctrl.pool == POOL_RES) r_res_ptr <= r_cur;
                else r_gen_ptr <= r_cur;
                if (i_ctrl.fill_mode) r_top <= top_m1;
            end
            if (i_ctrl.pop_rd) r_top <= r_top + TW'(1);
            if (i_ctrl.push) r_top <= top_m1;
            if (i_ctrl.out_load) r_out_stat <= r_stat;
            if (i_ctrl.clr_start) r_clr <= '0;
            else if (i_ctrl.clr_step) r_clr <= r_clr + BWX'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_kind  <= i_kind;
            r_frame <= i_frame;
        end
        if (i_ctrl.scan_start) begin
            r_cur     <= p_first;
            r_first   <= p_first;
            r_start   <= p_start;
            r_end     <= p_end;
            r_wrapped <= 1'b0;
        end else if (i_ctrl.scan_chk) begin
            r_cur     <= nxt;
            r_wrapped <= nxt_wrap;
        end
        if (i_ctrl.scan_chk && hit) begin
            r_res  <= 15'(LW'(r_cur) * LW'(8) + LW'(fbit));
            r_stat <= 1'b0;
        end else if (i_ctrl.pop_done) begin
            r_res  <= r_sdata;
            r_stat <= 1'b0;
        end else if (i_ctrl.fail) begin
            r_res  <= '0;
            r_stat <= 1'b1;
        end else if (i_ctrl.zero_res) begin
            r_res  <= '0;
            r_stat <= 1'b0;
        end
        if (i_ctrl.out_load) r_out_frame <= r_res;
    end

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.frame_ok    = (LW'(r_frame) < LW'(FRAME_COUNT));
        o_stat.stack_empty = (r_top == TW'(STACK_DEPTH));
        o_stat.stack_full  = (r_top == '0);
        o_stat.clr_done    = (r_clr == BWX'(MAP_BYTES - 1));
        o_stat.scan_hit    = hit;
        o_stat.scan_last   = last;
        o_stat.pool_empty  = (p_start >= p_end);
    end

    assign o_frame_out = r_out_frame;
    assign o_status    = r_out_stat;
endmodule

// ===== hdl/pfa_ctrl.sv =====
// Controller state machine of the page frame allocator.
// Depends on pfa_pkg.
module pfa_ctrl import pfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_xfer,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy,
    output logic  o_out_load
);
    t_state r_state, n_state;
    logic   r_fill, n_fill;
    logic   r_pool_res, n_pool_res;
    logic   r_popped, r_scanned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RST_CLR;
            r_fill     <= 1'b0;
            r_pool_res <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_pool_res <= n_pool_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_pool_res = r_pool_res;
        case (r_state)
            S_RST_CLR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE: if (i_in_xfer) n_state = S_DECODE;
            S_DECODE: begin
                n_fill = 1'b0;
                n_pool_res = 1'b0;
                case (i_stat.kind)
                    KIND_ALLOC: begin
                        if (!i_stat.stack_empty) n_state = S_POP_RD;
                        else if (i_stat.pool_empty) n_state = S_RESULT;
                        else n_state = S_SCAN_RD;
                    end
                    KIND_FREE: begin
                        if (!i_stat.frame_ok) n_state = S_RESULT;
                        else if (!i_stat.stack_full) n_state = S_RESULT;
                        else n_state = S_FREE_RD;
                    end
                    KIND_RALLOC: begin
                        n_pool_res = 1'b1;
                        n_state = S_RESULT;
                        if (!(i_stat.pool_empty)) n_state = S_SCAN_RD;
                    end
                    KIND_RFREE: n_state = i_stat.frame_ok ? S_FREE_RD : S_RESULT;
                    KIND_INIT: n_state = S_CLEAR;
                    default: n_state = S_RESULT;
                endcase
            end
            S_CLEAR: if (i_stat.clr_done) begin
                n_fill = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: n_state = (i_stat.pool_empty || i_stat.stack_full) ? S_RESULT : S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_stat.scan_hit) n_state = r_fill ? S_FILL : S_RESULT;
                else if (i_stat.scan_last) n_state = S_RESULT;
                else n_state = S_SCAN_RD;
            end
            S_POP_RD: n_state = S_RESULT;
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_RESULT;
            S_RESULT: if (i_out_free && !r_popped) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_popped  <= 1'b0;
            r_scanned <= 1'b0;
        end else begin
            r_popped  <= (r_state == S_POP_RD);
            r_scanned <= (r_state == S_SCAN_CHK) && (i_stat.scan_hit || !r_fill);
        end
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.pool = r_pool_res ? POOL_RES : POOL_GEN;
        o_ctrl.fill_mode = r_fill;
        case (r_state)
            S_RST_CLR: begin
                o_ctrl.clr_step = 1'b1;
                o_ctrl.clr_zero = 1'b1;
            end
            S_IDLE: o_ctrl.capture = i_in_xfer;
            S_DECODE: begin
                o_ctrl.pool = (i_stat.kind == KIND_RALLOC) ? POOL_RES : POOL_GEN;
                o_ctrl.scan_start = 1'b1;
                o_ctrl.clr_start  = 1'b1;
                o_ctrl.zero_res   = 1'b1;
                if (i_stat.kind == KIND_ALLOC && i_stat.stack_empty && i_stat.pool_empty)
                    o_ctrl.fail = 1'b1;
                if (i_stat.kind == KIND_RALLOC && i_stat.pool_empty)
                    o_ctrl.fail = 1'b1;
                if (i_stat.kind == KIND_FREE && i_stat.frame_ok && !i_stat.stack_full)
                    o_ctrl.push = 1'b1;
            end
            S_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
                if (i_stat.clr_done) o_ctrl.init_ptrs = 1'b1;
            end
            S_FILL: begin
                o_ctrl.scan_start = 1'b1;
                // initialize reports frame 0 once filling stops
                if (i_stat.pool_empty || i_stat.stack_full) o_ctrl.zero_res = 1'b1;
            end
            S_SCAN_RD: o_ctrl.scan_rd = 1'b1;
            S_SCAN_CHK: begin
                o_ctrl.scan_chk = 1'b1;
                if (!i_stat.scan_hit && i_stat.scan_last && !r_fill) o_ctrl.fail = 1'b1;
                if (!i_stat.scan_hit && i_stat.scan_last && r_fill) o_ctrl.zero_res = 1'b1;
            end
            S_POP_RD: o_ctrl.pop_rd = 1'b1;
            S_FREE_RD: o_ctrl.bit_rd = 1'b1;
            S_FREE_WR: o_ctrl.bit_clr = 1'b1;
            S_RESULT: begin
                if (r_popped) o_ctrl.pop_done = 1'b1;
                if (r_fill && r_scanned) o_ctrl.zero_res = 1'b1;
                // a popped entry passes the stack read register first
                o_ctrl.out_load = i_out_free && !r_popped;
            end
            default: ;
        endcase
        if (r_state == S_RESULT && r_fill) o_ctrl.zero_res = 1'b1;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_out_load = o_ctrl.out_load;
endmodule

// ===== hdl/page_frame_allocator.sv =====
// Page frame allocator: used-bitmap with a cache stack of free frame numbers.
// A push, an unused kind or an empty pool goes straight from decode to the result; a stack pop
// reads the stack top, a bitmap free reads then writes the byte, and a scan reads and checks one byte at a time.
// Initialize adds a map sweep, then a scan for each cached frame.
// One item in flight: the next input is taken the cycle after the result is loaded.
// Reset (synchronous, active low): zeroing sweep of the map with input held off, stack empty.
module page_frame_allocator import pfa_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] frame
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [14:0] frame_out
    output logic        m_axis_tuser,   // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_usable, r_res_low, r_res_high;
    logic        r_ovalid;
    t_ctrl ctrl;
    t_stat stat;
    logic  busy, out_load;
    logic [14:0] frame_out;
    logic        status;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable   <= 16'd8192;
            r_res_low  <= 16'd256;
            r_res_high <= 16'd512;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_USABLE:   r_usable   <= i_cfg_data;
                CFG_RES_LOW:  r_res_low  <= i_cfg_data;
                CFG_RES_HIGH: r_res_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;

    pfa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_xfer(s_axis_tvalid && s_axis_tready),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_stat(stat), .o_ctrl(ctrl), .o_busy(busy), .o_out_load(out_load)
    );

    pfa_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_kind(s_axis_tuser), .i_frame(s_axis_tdata[14:0]),
        .i_usable(r_usable), .i_res_low(r_res_low), .i_res_high(r_res_high),
        .o_frame_out(frame_out), .o_status(status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, frame_out};
    assign m_axis_tuser  = status;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("input taken while busy");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("failed result carries a frame");
`endif
endmodule

// ===== tb/page_frame_allocator_tb.sv =====
// Self-checking bench for page_frame_allocator: random and directed allocate/free traffic,
// checked against a behavioural copy of the bitmap, the stack and the scan pointers.
// Depends on pfa_pkg and page_frame_allocator.
module page_frame_allocator_tb;
    import pfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = 32768;
    localparam int DEPTH = 32;
    localparam int MAP_BYTES = FRAMES / 8;

    typedef struct {
        logic [2:0]  kind;
        logic [14:0] frame;
    } t_req;

    typedef struct {
        logic [14:0] frame;
        logic        status;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    page_frame_allocator dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // behavioural allocator state
    byte unsigned used_bytes [MAP_BYTES];
    int unsigned  cached [DEPTH];
    int unsigned  cache_top = DEPTH;
    int unsigned  gen_ptr = 0;
    int unsigned  res_ptr = 0;
    int unsigned  reg_usable = 8192;
    int unsigned  reg_low = 256;
    int unsigned  reg_high = 512;

    t_req   pending [$];
    t_grant grants_due [$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     grants_seen = 0;
    int     fails_seen = 0;
    int     max_gap = 6;
    int     max_stall = 6;
    int     gap_left = 0;
    int     stall_left = 0;
    bit     in_xfer = 0;
    bit     out_xfer = 0;

    function automatic int unsigned frame_limit();
        return reg_usable < FRAMES ? reg_usable : FRAMES;
    endfunction

    function automatic int unsigned byte_idx(int unsigned f);
        return (f / 8) < MAP_BYTES ? f / 8 : MAP_BYTES;
    endfunction

    function automatic bit take_lowest(int unsigned b, int unsigned lim,
                                       ref int unsigned ptr, output int unsigned got);
        int unsigned base;
        int unsigned m;
        base = b * 8;
        m = ~used_bytes[b] & 8'hFF;
        got = 0;
        if (base >= lim)
            return 0;
        if (lim - base < 8)
            m &= (1 << (lim - base)) - 1;
        if (m == 0)
            return 0;
        for (int k = 0; k < 8; k++) begin
            if (m[k]) begin
                used_bytes[b] |= 8'(1 << k);
                ptr = b;
                got = b * 8 + k;
                return 1;
            end
        end
        return 0;
    endfunction

    // next-fit byte scan of [lo, hi) from ptr, wrapping back to lo
    function automatic bit next_fit(int unsigned lo, int unsigned hi,
                                    ref int unsigned ptr, output int unsigned got);
        int unsigned p;
        int unsigned lim;
        lim = frame_limit();
        p = ptr;
        got = 0;
        if (p < lo || p >= hi)
            p = lo;
        for (int unsigned b = p; b < hi; b++)
            if (take_lowest(b, lim, ptr, got))
                return 1;
        for (int unsigned b = lo; b < p; b++)
            if (take_lowest(b, lim, ptr, got))
                return 1;
        return 0;
    endfunction

    function automatic bit general_take(output int unsigned got);
        return next_fit(byte_idx(reg_high), (frame_limit() + 7) / 8, gen_ptr, got);
    endfunction

    function automatic t_grant allocate_outcome(t_req r);
        t_grant g;
        int unsigned f;
        g.frame = '0;
        g.status = 1'b0;
        case (r.kind)
            KIND_ALLOC: begin
                if (cache_top < DEPTH) begin
                    g.frame = 15'(cached[cache_top]);
                    cache_top++;
                end else if (general_take(f)) begin
                    g.frame = 15'(f);
                end else begin
                    g.status = 1'b1;
                end
            end
            KIND_FREE: begin
                if (cache_top > 0) begin
                    cache_top--;
                    cached[cache_top] = r.frame;
                end else begin
                    used_bytes[r.frame / 8] &= ~8'(1 << (r.frame % 8));
                end
            end
            KIND_RALLOC: begin
                if (next_fit(byte_idx(reg_low), byte_idx(reg_high), res_ptr, f))
                    g.frame = 15'(f);
                else
                    g.status = 1'b1;
            end
            KIND_RFREE: used_bytes[r.frame / 8] &= ~8'(1 << (r.frame % 8));
            KIND_INIT: begin
                for (int b = 0; b < MAP_BYTES; b++)
                    used_bytes[b] = (b < byte_idx(reg_low)) ? 8'hFF : 8'h00;
                gen_ptr = byte_idx(reg_high);
                res_ptr = byte_idx(reg_low);
                cache_top = DEPTH;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!general_take(f))
                        break;
                    cache_top--;
                    cached[cache_top] = f;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // transfer bookkeeping, prediction and checking
    always @(posedge i_clk) begin
        t_grant want;
        t_req   r;
        in_xfer = s_axis_tvalid && s_axis_tready;
        out_xfer = m_axis_tvalid && m_axis_tready;
        if (in_xfer) begin
            r.kind = s_axis_tuser;
            r.frame = s_axis_tdata[14:0];
            grants_due.push_back(allocate_outcome(r));
        end
        if (out_xfer) begin
            grants_seen++;
            if (m_axis_tuser)
                fails_seen++;
            if (grants_due.size() == 0) begin
                report($sformatf("unexpected result frame %0d status %0b",
                                 m_axis_tdata, m_axis_tuser));
            end else begin
                want = grants_due.pop_front();
                if (m_axis_tdata !== {1'b0, want.frame})
                    report($sformatf("frame_out %0d, expected %0d", m_axis_tdata, want.frame));
                if (m_axis_tuser !== want.status)
                    report($sformatf("status %0b, expected %0b", m_axis_tuser, want.status));
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && !(s_axis_tvalid && !in_xfer)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                r = pending.pop_front();
                s_axis_tuser <= r.kind;
                s_axis_tdata <= {1'b0, r.frame};
                s_axis_tvalid <= 1'b1;
                items_sent++;
                gap_left = $urandom_range(0, max_gap);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_xfer)
                stall_left = $urandom_range(0, max_stall);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(val);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_USABLE:   reg_usable = val;
            CFG_RES_LOW:  reg_low = val;
            default:      reg_high = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(input logic [2:0] k, input int unsigned f);
        t_req r;
        r.kind = k;
        r.frame = 15'(f);
        pending.push_back(r);
    endtask

    // sampled at the rising edge so a request popped by the driver is already on the bus
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || grants_due.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    // random traffic: mostly alloc/free around the live pools, some wild frees and odd kinds
    task automatic random_traffic(input int n);
        int unsigned hint;
        int unsigned pick;
        hint = frame_limit() + 8;
        if (hint > FRAMES)
            hint = FRAMES;
        queue_req(KIND_INIT, $urandom_range(0, 32767));
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                queue_req(KIND_ALLOC, $urandom_range(0, 32767));
            else if (pick < 65)
                queue_req(KIND_FREE, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 32767) : $urandom_range(0, hint - 1));
            else if (pick < 80)
                queue_req(KIND_RALLOC, $urandom_range(0, 32767));
            else if (pick < 92)
                queue_req(KIND_RFREE, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 32767) : $urandom_range(0, hint - 1));
            else if (pick < 94)
                queue_req(KIND_INIT, $urandom_range(0, 32767));
            else
                queue_req(3'($urandom_range(5, 7)), $urandom_range(0, 32767));
        end
    endtask

    int unsigned setups [6][3] = '{
        '{64, 0, 16}, '{8, 0, 0}, '{32768, 32768, 32768},
        '{200, 13, 100}, '{32768, 0, 8}, '{100, 40, 0}
    };

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: map must be initialised before it is trusted
        queue_req(KIND_INIT, 0);
        queue_req(KIND_ALLOC, 32767);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 0);
        queue_req(KIND_FREE, 32767);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_RALLOC, 0);
        queue_req(KIND_RALLOC, 0);
        queue_req(KIND_RFREE, 256);
        queue_req(KIND_RFREE, 32767);
        queue_req(KIND_RFREE, 0);
        queue_req(KIND_RALLOC, 0);
        queue_req(3'd5, 32767);
        queue_req(3'd6, 21845);
        queue_req(3'd7, 10922);
        queue_req(KIND_FREE, 5);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_INIT, 32767);
        queue_req(KIND_ALLOC, 0);
        wait_drained();
        random_traffic(80);
        wait_drained();

        foreach (setups[p]) begin
            cfg_write(CFG_USABLE, setups[p][0]);
            cfg_write(CFG_RES_LOW, setups[p][1]);
            cfg_write(CFG_RES_HIGH, setups[p][2]);
            // alternate between bursty and back-to-back traffic
            max_gap = (p % 2) ? 0 : 6;
            max_stall = (p % 3 == 1) ? 0 : 6;
            random_traffic(90);
            wait_drained();
        end

        repeat (50) @(negedge i_clk);
        $display("covered %0d requests over 7 pool layouts; %0d results, %0d out-of-frames",
                 items_sent, grants_seen, fails_seen);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #40ms;
        $display("timed out with %0d results outstanding", grants_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/pfa_pkg.sv
hdl/pfa_datapath.sv
hdl/pfa_ctrl.sv
hdl/page_frame_allocator.sv
tb/page_frame_allocator_tb.sv
